// ===== src/crgb_pkg.sv =====
// Shared types and constants for the chess record game boundary scanner.
// Byte classes, queue entry, scan modes and the terminator match table.
// No dependencies.
package crgb_pkg;

  typedef enum logic [3:0] {
    CLS_END,
    CLS_LF,
    CLS_CR,
    CLS_BLANK,
    CLS_LBRACKET,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_STAR,
    CLS_ONE,
    CLS_ZERO,
    CLS_DASH,
    CLS_SLASH,
    CLS_TWO,
    CLS_OTHER
  } crgb_cls_e;

  typedef struct packed {
    crgb_cls_e cls;
  } crgb_entry_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_FOUND = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;
  localparam logic [1:0] KIND_OPEN  = 2'd3;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_HEADER  = 2'd1;
  localparam logic [1:0] MODE_MOVES   = 2'd2;
  localparam logic [1:0] MODE_COMMENT = 2'd3;

  localparam logic [1:0] HDR_LINE_START = 2'd0;
  localparam logic [1:0] HDR_IN_LINE    = 2'd1;
  localparam logic [1:0] HDR_CR_LINE    = 2'd2;

  // partial terminator states: "", 1, 1-, 0, 0-, 1/, 1/2, 1/2-, 1/2-1, 1/2-1/
  localparam logic [3:0] M_NONE  = 4'd0;
  localparam logic [3:0] M_1     = 4'd1;
  localparam logic [3:0] M_1D    = 4'd2;
  localparam logic [3:0] M_0     = 4'd3;
  localparam logic [3:0] M_0D    = 4'd4;
  localparam logic [3:0] M_1S    = 4'd5;
  localparam logic [3:0] M_1S2   = 4'd6;
  localparam logic [3:0] M_1S2D  = 4'd7;
  localparam logic [3:0] M_1S2D1 = 4'd8;
  localparam logic [3:0] M_1S2D1S = 4'd9;
  localparam logic [3:0] M_HIT   = 4'd10;

  function automatic crgb_cls_e classify(input logic [7:0] b, input logic last);
    crgb_cls_e c;
    if (last || b == 8'hFF) begin
      c = CLS_END;
    end else begin
      unique case (b)
        8'h0A: c = CLS_LF;
        8'h0D: c = CLS_CR;
        8'h09, 8'h0B, 8'h20, 8'h00: c = CLS_BLANK;
        8'h5B: c = CLS_LBRACKET;
        8'h7B: c = CLS_LBRACE;
        8'h7D: c = CLS_RBRACE;
        8'h2A: c = CLS_STAR;
        8'h31: c = CLS_ONE;
        8'h30: c = CLS_ZERO;
        8'h2D: c = CLS_DASH;
        8'h2F: c = CLS_SLASH;
        8'h32: c = CLS_TWO;
        default: c = CLS_OTHER;
      endcase
    end
    return c;
  endfunction

  function automatic logic [3:0] match_next(input logic [3:0] s, input crgb_cls_e c);
    logic [3:0] n;
    n = M_NONE;
    unique case (c)
      CLS_STAR: n = M_HIT;
      CLS_ONE:  n = (s == M_0D) ? M_HIT : (s == M_1S2D) ? M_1S2D1 : M_1;
      CLS_ZERO: n = (s == M_1D) ? M_HIT : M_0;
      CLS_DASH: begin
        unique case (s)
          M_1:     n = M_1D;
          M_0:     n = M_0D;
          M_1S2:   n = M_1S2D;
          M_1S2D1: n = M_1D;
          default: n = M_NONE;
        endcase
      end
      CLS_SLASH: n = (s == M_1) ? M_1S : (s == M_1S2D1) ? M_1S2D1S : M_NONE;
      CLS_TWO:   n = (s == M_1S) ? M_1S2 : (s == M_1S2D1S) ? M_HIT : M_NONE;
      default:   n = M_NONE;
    endcase
    return n;
  endfunction

endpackage

// ===== src/crgb_front.sv =====
// Front end: sorts each accepted byte into a character class.
// Depends on crgb_pkg.
module crgb_front
  import crgb_pkg::*;
(
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output crgb_entry_t entry_o
);

  always_comb begin
    entry_o.cls = classify(data_byte_i, stream_end_i);
  end

endmodule

// ===== src/crgb_queue.sv =====
// Two-entry queue between front end and scan engine.
// Depends on crgb_pkg.
module crgb_queue
  import crgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  crgb_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output crgb_entry_t entry_o
);

  localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  crgb_entry_t mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== src/crgb_back.sv =====
// Scan engine: game/header/move/comment modes, terminator matching,
// offsets, game count and the registered result stage. Depends on crgb_pkg.
module crgb_back
  import crgb_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  crgb_entry_t entry_i,
  output logic        pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o
);

  logic [1:0] mode_q, mode_d;
  logic [1:0] hdr_q, hdr_d;
  logic [3:0] match_q, match_d, match_nx;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_inc, begin_q, begin_d;
  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic stopped_q, stopped_d;

  logic out_valid_q;
  logic [1:0] kind_q, kind_d;
  logic [OFFSET_BITS-1:0] rb_q, rb_d, re_q, re_d;
  logic [COUNT_BITS-1:0] rc_q, rc_d;
  logic emit;
  logic is_blank;

  logic [OFFSET_BITS+31:0] rb_ext, re_ext;
  logic [COUNT_BITS+15:0] rc_ext;

  assign pop_o     = valid_i && (!out_valid_q || m_axis_tready_i);
  assign pos_inc   = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign match_nx  = match_next(match_q, entry_i.cls);
  assign is_blank  = (entry_i.cls == CLS_LF) || (entry_i.cls == CLS_CR) ||
                     (entry_i.cls == CLS_BLANK);

  always_comb begin
    mode_d    = mode_q;
    hdr_d     = hdr_q;
    match_d   = match_q;
    pos_d     = pos_q;
    begin_d   = begin_q;
    count_d   = count_q;
    stopped_d = stopped_q;
    emit      = 1'b0;
    kind_d    = kind_q;
    rb_d      = rb_q;
    re_d      = re_q;
    rc_d      = rc_q;
    if (pop_o && !stopped_q) begin
      if (entry_i.cls == CLS_END) begin
        stopped_d = 1'b1;
        emit      = 1'b1;
        kind_d    = (mode_q == MODE_IDLE) ? KIND_DONE : KIND_OPEN;
        rb_d      = (mode_q == MODE_IDLE) ? '0 : begin_q;
        re_d      = pos_q;
        rc_d      = count_q;
      end else begin
        pos_d = pos_inc;
        if (mode_q == MODE_HEADER) begin
          unique case (hdr_q)
            HDR_IN_LINE: begin
              if (entry_i.cls == CLS_LF) hdr_d = HDR_LINE_START;
            end
            HDR_CR_LINE: begin
              if (entry_i.cls == CLS_LF) mode_d = MODE_MOVES;
            end
            default: begin
              if (entry_i.cls == CLS_LF) begin
                mode_d = MODE_MOVES;
              end else if (entry_i.cls == CLS_CR) begin
                hdr_d = HDR_CR_LINE;
              end else begin
                hdr_d = HDR_IN_LINE;
              end
            end
          endcase
        end else if (is_blank) begin
          match_d = M_NONE;
        end else if (mode_q == MODE_IDLE) begin
          if (entry_i.cls == CLS_LBRACKET) begin
            begin_d = pos_q;
            mode_d  = MODE_HEADER;
            hdr_d   = HDR_LINE_START;
            match_d = M_NONE;
          end else begin
            stopped_d = 1'b1;
            emit      = 1'b1;
            kind_d    = KIND_BAD;
            rb_d      = '0;
            re_d      = pos_q;
            rc_d      = count_q;
          end
        end else if (mode_q == MODE_COMMENT) begin
          if (entry_i.cls == CLS_RBRACE) mode_d = MODE_MOVES;
        end else if (entry_i.cls == CLS_LBRACE) begin
          match_d = M_NONE;
          mode_d  = MODE_COMMENT;
        end else if (match_nx == M_HIT) begin
          match_d = M_NONE;
          count_d = count_inc;
          mode_d  = MODE_IDLE;
          emit    = 1'b1;
          kind_d  = KIND_FOUND;
          rb_d    = begin_q;
          re_d    = pos_inc;
          rc_d    = count_inc;
          begin_d = '0;
        end else begin
          match_d = match_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      hdr_q       <= HDR_LINE_START;
      match_q     <= M_NONE;
      pos_q       <= '0;
      begin_q     <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      hdr_q     <= hdr_d;
      match_q   <= match_d;
      pos_q     <= pos_d;
      begin_q   <= begin_d;
      count_q   <= count_d;
      stopped_q <= stopped_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rb_q   <= rb_d;
    re_q   <= re_d;
    rc_q   <= rc_d;
  end

  assign rb_ext = {32'd0, rb_q};
  assign re_ext = {32'd0, re_q};
  assign rc_ext = {16'd0, rc_q};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, rc_ext[15:0], re_ext[31:0], rb_ext[31:0], kind_q};

endmodule

// ===== src/chess_record_game_boundary_scanner.sv =====
// Chess record game boundary scanner, top level.
// An accepted byte goes into the queue; the scan engine takes it from there
// and registers its result, if any, in the result stage. Throughput: one byte
// per cycle, set by the mode/terminator update, if no result awaits tready.
// Reset (rst_ni low, asynchronous) clears mode, offsets, count, stop flag
// and the queue; result payload registers are not reset.
module chess_record_game_boundary_scanner
  import crgb_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // [1:0] result_kind, [33:2] game_begin,
                                      // [65:34] game_end, [81:66] game_count
);

  crgb_entry_t front_entry, queue_entry;
  logic q_full, q_empty, q_pop;

  crgb_front u_front (
    .data_byte_i  (s_axis_tdata),
    .stream_end_i (s_axis_tuser),
    .entry_o      (front_entry)
  );

  crgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (queue_entry)
  );

  crgb_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (!q_empty),
    .entry_i         (queue_entry),
    .pop_o           (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  assign s_axis_tready = !q_full;

endmodule

// ===== bench/tb_chess_record_game_boundary_scanner.sv =====
// Self-checking bench for the chess record game boundary scanner: a directed byte table,
// then predicted randomized game records with random gaps and a long output hold-off.
// Depends on crgb_pkg and the scanner top level; no files or arguments are read.
module tb_chess_record_game_boundary_scanner
  import crgb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GAP_MAX        = 14;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AT        = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned MIN_GAMES      = 40;
  localparam int unsigned DIR_ROWS       = 25;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_TWO      = 8'h32;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_STOP     = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] begin_off;
    logic [31:0] end_off;
    logic [15:0] count;
  } scan_result_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed;
    scan_result_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;

  chess_record_game_boundary_scanner i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // two games: header with a CR line, comment, overlapping result, broken partial match
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CH_NUL,      1'b0, 1'b0, '0},
    '{CH_LBRACKET, 1'b0, 1'b0, '0},
    '{8'hFE,       1'b0, 1'b0, '0},
    '{CH_LF,       1'b0, 1'b0, '0},
    '{CH_CR,       1'b0, 1'b0, '0},
    '{"x",         1'b0, 1'b0, '0},
    '{CH_LF,       1'b0, 1'b0, '0},
    '{CH_LBRACE,   1'b0, 1'b0, '0},
    '{CH_STAR,     1'b0, 1'b0, '0},
    '{CH_RBRACE,   1'b0, 1'b0, '0},
    '{CH_ONE,      1'b0, 1'b0, '0},
    '{CH_SLASH,    1'b0, 1'b0, '0},
    '{CH_TWO,      1'b0, 1'b0, '0},
    '{CH_DASH,     1'b0, 1'b0, '0},
    '{CH_ONE,      1'b0, 1'b0, '0},
    '{CH_DASH,     1'b0, 1'b0, '0},
    '{CH_ZERO,     1'b0, 1'b1, '{KIND_FOUND, 32'd1, 32'd17, 16'd1}},
    '{CH_TAB,      1'b0, 1'b0, '0},
    '{CH_LBRACKET, 1'b0, 1'b0, '0},
    '{CH_LF,       1'b0, 1'b0, '0},
    '{CH_ZERO,     1'b0, 1'b0, '0},
    '{CH_SP,       1'b0, 1'b0, '0},
    '{CH_ZERO,     1'b0, 1'b0, '0},
    '{CH_DASH,     1'b0, 1'b0, '0},
    '{CH_ONE,      1'b0, 1'b1, '{KIND_FOUND, 32'd18, 32'd25, 16'd2}}
  };

  string MOVE_CH = "abcdefghNBRQKxO+#=.345678";

  // scanner state as predicted
  logic [1:0]  sc_mode   = MODE_IDLE;
  logic [1:0]  sc_hdr    = HDR_LINE_START;
  logic [3:0]  sc_match  = M_NONE;
  logic [31:0] sc_pos    = '0;
  logic [31:0] sc_open   = '0;
  logic [15:0] sc_games  = '0;
  bit          sc_stopped = 1'b0;

  scan_result_t expected_results [$];
  logic [7:0]   game_text [$];

  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_found     = 0;
  int unsigned n_errors    = 0;
  bit          send_gappy  = 1'b1;
  bit          take_gappy  = 1'b1;
  bit          hold_request = 1'b0;
  bit          hold_active  = 1'b0;
  string       end_note;

  function automatic string partial_text(input logic [3:0] st);
    case (st)
      M_1:      return "1";
      M_1D:     return "1-";
      M_0:      return "0";
      M_0D:     return "0-";
      M_1S:     return "1/";
      M_1S2:    return "1/2";
      M_1S2D:   return "1/2-";
      M_1S2D1:  return "1/2-1";
      M_1S2D1S: return "1/2-1/";
      default:  return "";
    endcase
  endfunction

  function automatic string full_text(input int idx);
    case (idx)
      0:       return "*";
      1:       return "1-0";
      2:       return "0-1";
      default: return "1/2-1/2";
    endcase
  endfunction

  function automatic bit text_at(input logic [7:0] seq [8], input int from, input string pat);
    int j;
    for (j = 0; j < pat.len(); j++) begin
      if (seq[from + j] != pat[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // longest suffix of matched text plus c that is a full result or a result prefix
  function automatic logic [3:0] next_terminator(input logic [3:0] st, input logic [7:0] c);
    logic [7:0] seq [8];
    string      pre;
    string      pat;
    int         n;
    int         k;
    int         i;
    pre = partial_text(st);
    n = pre.len();
    for (i = 0; i < 8; i++) seq[i] = 8'h00;
    for (i = 0; i < n; i++) seq[i] = pre[i];
    seq[n] = c;
    n++;
    for (k = 0; k < n; k++) begin
      for (i = 0; i < 4; i++) begin
        pat = full_text(i);
        if (pat.len() == n - k && text_at(seq, k, pat)) return M_HIT;
      end
      for (i = 1; i < 10; i++) begin
        pat = partial_text(i[3:0]);
        if (pat.len() == n - k && text_at(seq, k, pat)) return i[3:0];
      end
    end
    return M_NONE;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_VT || c == CH_SP || c == CH_NUL;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic bit predict_scan(input logic [7:0] c, input bit last,
                                      output scan_result_t r);
    logic [31:0] here;
    here = sc_pos;
    r = '0;
    if (sc_stopped) return 1'b0;
    if (last || c == CH_STOP) begin
      sc_stopped = 1'b1;
      if (sc_mode == MODE_IDLE) r = '{KIND_DONE, 32'd0, sc_pos, sc_games};
      else r = '{KIND_OPEN, sc_open, sc_pos, sc_games};
      return 1'b1;
    end
    sc_pos = sat_inc(sc_pos);
    if (sc_mode == MODE_HEADER) begin
      if (sc_hdr == HDR_IN_LINE) begin
        if (c == CH_LF) sc_hdr = HDR_LINE_START;
      end else if (sc_hdr == HDR_CR_LINE) begin
        if (c == CH_LF) sc_mode = MODE_MOVES;
      end else if (c == CH_LF) begin
        sc_mode = MODE_MOVES;
      end else if (c == CH_CR) begin
        sc_hdr = HDR_CR_LINE;
      end else begin
        sc_hdr = HDR_IN_LINE;
      end
      return 1'b0;
    end
    if (is_blank(c)) begin
      sc_match = M_NONE;
      return 1'b0;
    end
    if (sc_mode == MODE_IDLE) begin
      if (c == CH_LBRACKET) begin
        sc_open  = here;
        sc_mode  = MODE_HEADER;
        sc_hdr   = HDR_LINE_START;
        sc_match = M_NONE;
        return 1'b0;
      end
      sc_stopped = 1'b1;
      r = '{KIND_BAD, 32'd0, here, sc_games};
      return 1'b1;
    end
    if (sc_mode == MODE_COMMENT) begin
      if (c == CH_RBRACE) sc_mode = MODE_MOVES;
      return 1'b0;
    end
    if (c == CH_LBRACE) begin
      sc_match = M_NONE;
      sc_mode  = MODE_COMMENT;
      return 1'b0;
    end
    sc_match = next_terminator(sc_match, c);
    if (sc_match != M_HIT) return 1'b0;
    sc_match = M_NONE;
    if (sc_games != '1) sc_games = sc_games + 16'd1;
    sc_mode = MODE_IDLE;
    r = '{KIND_FOUND, sc_open, sat_inc(here), sc_games};
    sc_open = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] not_a, input logic [7:0] not_b);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 254)); while (v == not_a || v == not_b);
    return v;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_LF;
      1:       return CH_CR;
      2:       return CH_TAB;
      3:       return CH_VT;
      4:       return CH_SP;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    game_text = {game_text, b};
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  // one game record: leading blanks, tag header, move text, result
  function automatic int build_game();
    int body_at;
    game_text.delete();
    repeat ($urandom_range(0, 3)) append_byte(pick_blank());
    body_at = game_text.size();
    append_byte(CH_LBRACKET);
    repeat ($urandom_range(0, 3)) begin
      append_byte(pick_byte(CH_LF, CH_CR));
      repeat ($urandom_range(0, 9)) append_byte(pick_byte(CH_LF, CH_LF));
      append_byte(CH_LF);
    end
    if ($urandom_range(0, 3) != 0) begin
      append_byte(CH_LF);
    end else begin
      append_byte(CH_CR);
      repeat ($urandom_range(0, 3)) append_byte(pick_byte(CH_LF, CH_LF));
      append_byte(CH_LF);
    end
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 5))
            append_byte(MOVE_CH[$urandom_range(0, MOVE_CH.len() - 1)]);
          append_byte(pick_blank());
        end
        5: begin
          append_byte(CH_LBRACE);
          repeat ($urandom_range(0, 8)) append_byte(pick_byte(CH_RBRACE, CH_RBRACE));
          append_byte(CH_RBRACE);
        end
        6: add_text(partial_text(4'($urandom_range(1, 9))));
        7: repeat ($urandom_range(1, 4)) append_byte(pick_byte(CH_LBRACE, CH_LBRACE));
        8: append_byte(pick_blank());
        default: add_text($urandom_range(0, 1) ? "12. " : "O-O ");
      endcase
    end
    if ($urandom_range(0, 1) != 0) append_byte(pick_blank());
    add_text(full_text($urandom_range(0, 3)));
    return body_at;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h (result %0d)",
             $time, what, got, want, n_checked);
  endtask

  task automatic offer(input logic [7:0] data, input bit last, input bit typed,
                       input scan_result_t want);
    int unsigned  gap;
    scan_result_t got;
    gap = (send_gappy && !hold_active) ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_scan(data, last, got))
      expected_results = {expected_results, (typed ? want : got)};
    n_sent++;
    if (n_sent == HOLD_AT) hold_request = 1'b1;
    if (n_sent % 50 == 0) send_gappy = ($urandom_range(0, 3) != 0);
  endtask

  // stops early when a stray result closes the game before its planned end
  task automatic send_game(input int body_at);
    int k;
    for (k = 0; k < game_text.size(); k++) begin
      offer(game_text[k], 1'b0, 1'b0, '0);
      if (k >= body_at && sc_mode == MODE_IDLE) break;
    end
  endtask

  task automatic check_result(input logic [87:0] d);
    scan_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, result_kind", 32'(d[1:0]), '0);
    end else begin
      want = expected_results.pop_front();
      if (d[1:0] != want.kind)
        report_mismatch("result_kind", 32'(d[1:0]), 32'(want.kind));
      if (d[33:2] != want.begin_off) report_mismatch("game_begin", d[33:2], want.begin_off);
      if (d[65:34] != want.end_off) report_mismatch("game_end", d[65:34], want.end_off);
      if (d[81:66] != want.count)
        report_mismatch("game_count", 32'(d[81:66]), 32'(want.count));
      if (want.kind == KIND_FOUND) n_found++;
    end
    n_checked++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side
  initial begin
    int unsigned w;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        w = HOLD_CYCLES;
      end else begin
        w = take_gappy ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      hold_active = 1'b0;
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result(m_axis_tdata);
      if (n_checked % 6 == 0) take_gappy = ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int          i;
    int          body_at;
    int unsigned end_case;
    logic [7:0]  b;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      offer(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

    while (n_sent - DIR_ROWS < RANDOM_ITEMS || sc_games < MIN_GAMES) begin
      body_at = build_game();
      send_game(body_at);
    end

    // a single way of ending the scan per run
    end_case = $urandom_range(0, 4);
    game_text.delete();
    case (end_case)
      0: end_note = "stream end between games";
      1: end_note = "stop byte between games";
      2: begin
        end_note = "end inside a header";
        append_byte(CH_LBRACKET);
        repeat ($urandom_range(0, 6)) append_byte(pick_byte(CH_STOP, CH_STOP));
      end
      3: begin
        end_note = "end inside a comment";
        add_text("[\n\ne4 {ab");
      end
      default: end_note = "bad byte between games";
    endcase
    send_game(game_text.size());
    if (end_case == 4) begin
      do b = 8'($urandom_range(0, 254)); while (is_blank(b) || b == CH_LBRACKET);
      offer(b, 1'b0, 1'b0, '0);
    end else if (end_case == 1 || (end_case != 0 && $urandom_range(0, 1) != 0)) begin
      offer(CH_STOP, 1'b0, 1'b0, '0);
    end else begin
      offer(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    end
    repeat (4) offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d request bytes (%0d directed), %0d results checked, %0d games closed.",
             n_sent, DIR_ROWS, n_checked, n_found);
    $display("Scan ended by %s; %0d mismatches.", end_note, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/crgb_pkg.sv
src/crgb_front.sv
src/crgb_queue.sv
src/crgb_back.sv
src/chess_record_game_boundary_scanner.sv
bench/tb_chess_record_game_boundary_scanner.sv
